// ===== rtl/triangle_perimeter_area_unit_defines.svh =====
// Assertion macros for the triangle perimeter and area unit.
// Expects clk_i and rst_ni in the scope that uses them.
`ifndef TRIANGLE_PERIMETER_AREA_UNIT_DEFINES_SVH
`define TRIANGLE_PERIMETER_AREA_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define TPA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define TPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tpa_pkg.sv =====
// Types and fixed widths shared by the triangle perimeter and area unit.
// No dependencies.
package tpa_pkg;

  localparam int unsigned COORD_W     = 16;
  localparam int unsigned FRAC_BITS   = 4;
  localparam int unsigned SIDE_FRAC   = 8;
  localparam int unsigned SQ_W        = 2 * COORD_W + 1;
  localparam int unsigned SIDE_RAD_W  = 42;
  localparam int unsigned SIDE_ROOT_W = SIDE_RAD_W / 2;
  localparam int unsigned P_W         = SIDE_ROOT_W + 2;
  localparam int unsigned HALF_W      = P_W;
  localparam int unsigned PROD_W      = 2 * P_W;
  localparam int unsigned FULL_W      = 2 * PROD_W;
  localparam int unsigned AREA_RAD_W  = 64;
  localparam int unsigned AREA_ROOT_W = AREA_RAD_W / 2;
  localparam int unsigned HERON_SHIFT = 28;
  localparam int unsigned PERIM_W     = 19;
  localparam int unsigned AREA_W      = 31;

  typedef struct packed {
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] dx_close;
    logic signed [COORD_W-1:0] dy_close;
  } tri_in_t;

  typedef struct packed {
    logic [PERIM_W-1:0] perimeter;
    logic [AREA_W-1:0]  area;
    logic               open_polygon;
    logic               negative_radicand;
  } tri_out_t;

  typedef struct packed {
    logic [PERIM_W-1:0] perim;
    logic               neg;
    logic               open_poly;
  } tag_t;

  typedef struct packed {
    logic [2:0][SQ_W-1:0] sq;
    logic                 open_poly;
  } sq_t;

  typedef struct packed {
    logic [3:0][P_W-1:0] fm;
    tag_t                tag;
  } heron_t;

  typedef struct packed {
    logic [1:0][PROD_W-1:0] l;
    tag_t                   tag;
  } mul_t;

  typedef struct packed {
    logic [3:0][PROD_W-1:0] pp;
    tag_t                   tag;
  } part_t;

  typedef struct packed {
    logic [AREA_RAD_W-1:0] rad;
    tag_t                  tag;
  } rad_t;

endpackage

// ===== rtl/tpa_pipe_reg.sv =====
// One valid/ready register stage carrying an opaque data word.
// No dependencies.
module tpa_pipe_reg #(
  parameter int unsigned W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  output logic         ready_o,
  input  logic [W-1:0] data_i,
  output logic         valid_o,
  input  logic         ready_i,
  output logic [W-1:0] data_o
);

  logic         valid_q;
  logic [W-1:0] data_q;

  // The stage takes a new beat whenever it is empty or its beat leaves.
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/tpa_sqrt_cell.sv =====
// One digit step of a square root, over several lanes, with its own stage register.
// No dependencies.
module tpa_sqrt_cell #(
  parameter int unsigned LANES = 1,
  parameter int unsigned RAD_W = 8,
  parameter int unsigned PAY_W = 1
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   valid_i,
  output logic                                   ready_o,
  input  logic [LANES-1:0][RAD_W-1:0]            x_i,
  input  logic [LANES-1:0][RAD_W/2+2:0]          rem_i,
  input  logic [LANES-1:0][RAD_W/2-1:0]          root_i,
  input  logic [PAY_W-1:0]                       pay_i,
  output logic                                   valid_o,
  input  logic                                   ready_i,
  output logic [LANES-1:0][RAD_W-1:0]            x_o,
  output logic [LANES-1:0][RAD_W/2+2:0]          rem_o,
  output logic [LANES-1:0][RAD_W/2-1:0]          root_o,
  output logic [PAY_W-1:0]                       pay_o
);

  localparam int unsigned ROOT_W = RAD_W / 2;
  localparam int unsigned REM_W  = ROOT_W + 3;

  logic                              valid_q;
  logic [LANES-1:0][RAD_W-1:0]       x_d, x_q;
  logic [LANES-1:0][REM_W-1:0]       rem_d, rem_q;
  logic [LANES-1:0][ROOT_W-1:0]      root_d, root_q;
  logic [PAY_W-1:0]                  pay_q;

  // Bring down the next two radicand bits and try the odd trial value 4r+1.
  always_comb begin
    logic [REM_W-1:0] rs;
    logic [REM_W-1:0] trial;
    logic             ge;
    for (int l = 0; l < LANES; l++) begin
      rs        = {rem_i[l][REM_W-3:0], x_i[l][RAD_W-1 -: 2]};
      trial     = {1'b0, root_i[l], 2'b01};
      ge        = (rs >= trial);
      rem_d[l]  = ge ? (rs - trial) : rs;
      root_d[l] = {root_i[l][ROOT_W-2:0], ge};
      x_d[l]    = {x_i[l][RAD_W-3:0], 2'b00};
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      x_q    <= x_d;
      rem_q  <= rem_d;
      root_q <= root_d;
      pay_q  <= pay_i;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign pay_o   = pay_q;

endmodule

// ===== rtl/triangle_perimeter_area_unit.sv =====
// Top level of the triangle perimeter and area unit (Heron's formula).
// Depends on tpa_pkg, tpa_pipe_reg, tpa_sqrt_cell and the defines header.
//
//   port group   direction   payload     handshake
//   in_*         input       tri_in_t    in_valid_i / in_ready_o
//   out_*        output      tri_out_t   out_valid_o / out_ready_i
//
// One triangle is taken every cycle unless a stalled output has filled the pipe.
// Most of the pipeline depth lies in the two digit-serial root chains: 21 cells for the
// three side lengths, which run as lanes, and 32 cells for the area.
// Reset clears only the valid bit of every stage.
// A stalled output holds only the stages that are full behind it; bubbles
// further up still close, so input is taken while the pipe has room.
`include "triangle_perimeter_area_unit_defines.svh"

module triangle_perimeter_area_unit
  import tpa_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  tri_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output tri_out_t out_data_o
);

  localparam int unsigned SIDE_REM_W = SIDE_ROOT_W + 3;
  localparam int unsigned AREA_REM_W = AREA_ROOT_W + 3;
  localparam int unsigned TAG_W      = $bits(tag_t);

  // ---------------------------------------------------------------- squares
  sq_t  sq_d, sq_q;
  logic s0_valid, s0_ready;

  always_comb begin
    logic signed [COORD_W-1:0] px [4];
    logic signed [COORD_W-1:0] py [4];
    logic [COORD_W:0]          ddx, ddy;
    logic [COORD_W-1:0]        mx, my;
    logic [2*COORD_W-1:0]      sqx, sqy;
    px[0] = in_data_i.ax;       py[0] = in_data_i.ay;
    px[1] = in_data_i.bx;       py[1] = in_data_i.by;
    px[2] = in_data_i.cx;       py[2] = in_data_i.cy;
    px[3] = in_data_i.dx_close; py[3] = in_data_i.dy_close;
    for (int i = 0; i < 3; i++) begin
      ddx = {px[i][COORD_W-1], px[i]} - {px[i+1][COORD_W-1], px[i+1]};
      ddy = {py[i][COORD_W-1], py[i]} - {py[i+1][COORD_W-1], py[i+1]};
      mx  = ddx[COORD_W] ? COORD_W'(-ddx) : ddx[COORD_W-1:0];
      my  = ddy[COORD_W] ? COORD_W'(-ddy) : ddy[COORD_W-1:0];
      sqx = mx * mx;
      sqy = my * my;
      sq_d.sq[i] = {1'b0, sqx} + {1'b0, sqy};
    end
    sq_d.open_poly = (px[3] != px[0]) || (py[3] != py[0]);
  end

  tpa_pipe_reg #(.W($bits(sq_t))) u_sq_reg (
    .clk_i, .rst_ni,
    .valid_i(in_valid_i), .ready_o(in_ready_o), .data_i(sq_d),
    .valid_o(s0_valid), .ready_i(s0_ready), .data_o(sq_q)
  );

  // ------------------------------------------------------- side root chain
  logic [SIDE_ROOT_W:0]                              sc_valid, sc_ready;
  logic [SIDE_ROOT_W:0][2:0][SIDE_RAD_W-1:0]         sc_x;
  logic [SIDE_ROOT_W:0][2:0][SIDE_REM_W-1:0]         sc_rem;
  logic [SIDE_ROOT_W:0][2:0][SIDE_ROOT_W-1:0]        sc_root;
  logic [SIDE_ROOT_W:0]                              sc_pay;

  // Side radicand is the squared length rescaled to 2*SIDE_FRAC fraction bits.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sc_x[0][i]    = {1'b0, sq_q.sq[i], {(2 * (SIDE_FRAC - FRAC_BITS)){1'b0}}};
      sc_rem[0][i]  = '0;
      sc_root[0][i] = '0;
    end
  end
  assign sc_valid[0] = s0_valid;
  assign s0_ready    = sc_ready[0];
  assign sc_pay[0]   = sq_q.open_poly;

  for (genvar k = 0; k < SIDE_ROOT_W; k++) begin : g_side
    tpa_sqrt_cell #(.LANES(3), .RAD_W(SIDE_RAD_W), .PAY_W(1)) u_cell (
      .clk_i, .rst_ni,
      .valid_i(sc_valid[k]), .ready_o(sc_ready[k]),
      .x_i(sc_x[k]), .rem_i(sc_rem[k]), .root_i(sc_root[k]), .pay_i(sc_pay[k]),
      .valid_o(sc_valid[k+1]), .ready_i(sc_ready[k+1]),
      .x_o(sc_x[k+1]), .rem_o(sc_rem[k+1]), .root_o(sc_root[k+1]), .pay_o(sc_pay[k+1])
    );
  end

  // ------------------------------------------------- perimeter and factors
  heron_t hr_d, hr_q;
  logic   s1_valid, s1_ready;

  always_comb begin
    logic [P_W-1:0] p;
    logic [P_W:0]   f;
    logic           zero;
    logic           odd;
    p    = P_W'(sc_root[SIDE_ROOT_W][0]) + P_W'(sc_root[SIDE_ROOT_W][1])
         + P_W'(sc_root[SIDE_ROOT_W][2]);
    zero = (p == '0);
    odd  = 1'b0;
    hr_d.fm[0] = p;
    for (int i = 0; i < 3; i++) begin
      f    = {1'b0, p} - {2'b00, sc_root[SIDE_ROOT_W][i], 1'b0};
      odd  = odd ^ f[P_W];
      zero = zero || (f == '0);
      hr_d.fm[i+1] = f[P_W] ? P_W'(-f) : f[P_W-1:0];
    end
    hr_d.tag.neg       = !zero && odd;
    hr_d.tag.perim     = p[P_W-1 -: PERIM_W];
    hr_d.tag.open_poly = sc_pay[SIDE_ROOT_W];
    // A negative product gives area zero: drop one factor to zero.
    if (hr_d.tag.neg) begin
      hr_d.fm[0] = '0;
    end
  end

  tpa_pipe_reg #(.W($bits(heron_t))) u_hr_reg (
    .clk_i, .rst_ni,
    .valid_i(sc_valid[SIDE_ROOT_W]), .ready_o(sc_ready[SIDE_ROOT_W]), .data_i(hr_d),
    .valid_o(s1_valid), .ready_i(s1_ready), .data_o(hr_q)
  );

  // ------------------------------------------------------ pairwise products
  mul_t ml_d, ml_q;
  logic s2_valid, s2_ready;

  assign ml_d.l[0] = hr_q.fm[0] * hr_q.fm[1];
  assign ml_d.l[1] = hr_q.fm[2] * hr_q.fm[3];
  assign ml_d.tag  = hr_q.tag;

  tpa_pipe_reg #(.W($bits(mul_t))) u_ml_reg (
    .clk_i, .rst_ni,
    .valid_i(s1_valid), .ready_o(s1_ready), .data_i(ml_d),
    .valid_o(s2_valid), .ready_i(s2_ready), .data_o(ml_q)
  );

  // ------------------------------------- partial products of the final product
  part_t pp_d, pp_q;
  logic  s3_valid, s3_ready;

  always_comb begin
    logic [HALF_W-1:0] al, ah, bl, bh;
    al = ml_q.l[0][HALF_W-1:0];
    ah = ml_q.l[0][PROD_W-1:HALF_W];
    bl = ml_q.l[1][HALF_W-1:0];
    bh = ml_q.l[1][PROD_W-1:HALF_W];
    pp_d.pp[0] = al * bl;
    pp_d.pp[1] = al * bh;
    pp_d.pp[2] = ah * bl;
    pp_d.pp[3] = ah * bh;
    pp_d.tag   = ml_q.tag;
  end

  tpa_pipe_reg #(.W($bits(part_t))) u_pp_reg (
    .clk_i, .rst_ni,
    .valid_i(s2_valid), .ready_o(s2_ready), .data_i(pp_d),
    .valid_o(s3_valid), .ready_i(s3_ready), .data_o(pp_q)
  );

  // ---------------------------------------------------- sum and rescale
  rad_t rad_d, rad_q;
  logic s4_valid, s4_ready;

  always_comb begin
    logic [FULL_W-1:0] full;
    logic [FULL_W-1:0] mid;
    mid  = FULL_W'(pp_q.pp[1]) + FULL_W'(pp_q.pp[2]);
    full = FULL_W'(pp_q.pp[0]) + (mid << HALF_W) + {pp_q.pp[3], {PROD_W{1'b0}}};
    rad_d.rad = full[HERON_SHIFT +: AREA_RAD_W];
    rad_d.tag = pp_q.tag;
  end

  tpa_pipe_reg #(.W($bits(rad_t))) u_rad_reg (
    .clk_i, .rst_ni,
    .valid_i(s3_valid), .ready_o(s3_ready), .data_i(rad_d),
    .valid_o(s4_valid), .ready_i(s4_ready), .data_o(rad_q)
  );

  // ------------------------------------------------------- area root chain
  logic [AREA_ROOT_W:0]                           ac_valid, ac_ready;
  logic [AREA_ROOT_W:0][0:0][AREA_RAD_W-1:0]      ac_x;
  logic [AREA_ROOT_W:0][0:0][AREA_REM_W-1:0]      ac_rem;
  logic [AREA_ROOT_W:0][0:0][AREA_ROOT_W-1:0]     ac_root;
  logic [AREA_ROOT_W:0][TAG_W-1:0]                ac_pay;

  assign ac_x[0][0]    = rad_q.rad;
  assign ac_rem[0][0]  = '0;
  assign ac_root[0][0] = '0;
  assign ac_pay[0]     = rad_q.tag;
  assign ac_valid[0]   = s4_valid;
  assign s4_ready      = ac_ready[0];

  for (genvar k = 0; k < AREA_ROOT_W; k++) begin : g_area
    tpa_sqrt_cell #(.LANES(1), .RAD_W(AREA_RAD_W), .PAY_W(TAG_W)) u_cell (
      .clk_i, .rst_ni,
      .valid_i(ac_valid[k]), .ready_o(ac_ready[k]),
      .x_i(ac_x[k]), .rem_i(ac_rem[k]), .root_i(ac_root[k]), .pay_i(ac_pay[k]),
      .valid_o(ac_valid[k+1]), .ready_i(ac_ready[k+1]),
      .x_o(ac_x[k+1]), .rem_o(ac_rem[k+1]), .root_o(ac_root[k+1]), .pay_o(ac_pay[k+1])
    );
  end

  // --------------------------------------------------------- output stage
  tri_out_t out_d;
  tag_t     fin_tag;
  logic [AREA_ROOT_W-1:0] fin_root;

  assign fin_tag  = ac_pay[AREA_ROOT_W];
  assign fin_root = ac_root[AREA_ROOT_W][0];

  always_comb begin
    out_d.perimeter         = fin_tag.perim;
    out_d.area              = fin_root[AREA_ROOT_W-1:AREA_W] != '0 ? {AREA_W{1'b1}}
                                                                  : fin_root[AREA_W-1:0];
    out_d.open_polygon      = fin_tag.open_poly;
    out_d.negative_radicand = fin_tag.neg;
  end

  tpa_pipe_reg #(.W($bits(tri_out_t))) u_out_reg (
    .clk_i, .rst_ni,
    .valid_i(ac_valid[AREA_ROOT_W]), .ready_o(ac_ready[AREA_ROOT_W]), .data_i(out_d),
    .valid_o(out_valid_o), .ready_i(out_ready_i), .data_o(out_data_o)
  );

  // ------------------------------------------------------------ assertions
  `TPA_ASSERT_NOW(a_neg_area_zero, out_valid_o && out_data_o.negative_radicand,
    out_data_o.area == '0, "negative radicand with nonzero area")
  `TPA_ASSERT_NOW(a_perim_zero_area_zero, out_valid_o && (out_data_o.perimeter == '0),
    out_data_o.area == '0, "zero perimeter with nonzero area")
  `TPA_ASSERT_NEXT(a_accept_fills_stage, in_valid_i && in_ready_o,
    s0_valid, "accepted beat did not reach the first stage")
  `TPA_ASSERT_NOW(a_neg_factor_dropped, s1_valid && hr_q.tag.neg,
    hr_q.fm[0] == '0, "negative product kept a nonzero factor")

endmodule
